>>> hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W  = 9;
	localparam int SAT_W  = 9;

	// The dividers work on a 16-bit dividend and an 8-bit divisor. Both quotients
	// are known to stay below 2**DIV_Q_W, so only the low DIV_Q_W dividend bits
	// need a shift-and-subtract step.
	localparam int DIV_N_W    = 16;
	localparam int DIV_Q_W    = 9;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;

	// Hue is a sector offset plus a quotient in 0..120.
	localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 9'd60;
	localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 9'd180;
	localparam logic [HUE_W-1:0] HUE_OFS_RED   = 9'd300;
	localparam logic [HUE_W-1:0] HUE_FULL      = 9'd360;

	typedef enum logic [1:0] {
		SECT_RED   = 2'b00,
		SECT_GREEN = 2'b01,
		SECT_BLUE  = 2'b10
	} sector_t;

	typedef struct packed {
		logic [DIV_N_W-1:0] hue_num;
		logic [DIV_N_W-1:0] sat_num;
		logic [CHAN_W-1:0]  delta;
		logic [CHAN_W-1:0]  maxv;
		sector_t            sector;
		logic               grey;
		logic               black;
	} front_t;

	typedef struct packed {
		sector_t           sector;
		logic              grey;
		logic              black;
		logic [CHAN_W-1:0] maxv;
	} side_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   rem;
		logic [DIV_STEP-1:0] quo;
	} div_step_t;

	// A few restoring-division steps: one quotient bit per step.
	function automatic div_step_t div_step(logic [CHAN_W-1:0] rem,
		logic [DIV_STEP-1:0] bits, logic [CHAN_W-1:0] dvs);
		logic [CHAN_W:0] trial;
		div_step_t       res;
		res.rem = rem;
		res.quo = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			trial = {res.rem, bits[i]};
			if (trial >= {1'b0, dvs}) begin
				trial = trial - {1'b0, dvs};
				res.quo[i] = 1'b1;
			end
			res.rem = trial[CHAN_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> hdl/rgbhsv_rgb_if.sv
interface rgbhsv_rgb_if;
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> hdl/rgbhsv_hsv_if.sv
interface rgbhsv_hsv_if;
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue;
	logic [SAT_W-1:0]  saturation;
	logic [CHAN_W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

>>> hdl/rgbhsv_front.sv
module rgbhsv_front (
	input  logic                     clk,
	input  logic                     load,
	input  logic [rgbhsv_pkg::CHAN_W-1:0] red,
	input  logic [rgbhsv_pkg::CHAN_W-1:0] green,
	input  logic [rgbhsv_pkg::CHAN_W-1:0] blue,
	output rgbhsv_pkg::front_t       front
);
	import rgbhsv_pkg::*;

	logic [CHAN_W-1:0] maxv;
	logic [CHAN_W-1:0] minv;
	logic [CHAN_W-1:0] delta;
	logic [CHAN_W-1:0] pos;
	logic [CHAN_W-1:0] neg;
	logic [CHAN_W+1:0] span;
	logic [DIV_N_W-1:0] span_ext;
	sector_t           sector;
	front_t            front_s1;

	always_comb begin
		maxv = red;
		if (blue > maxv) maxv = blue;
		if (green > maxv) maxv = green;
		minv = red;
		if (blue < minv) minv = blue;
		if (green < minv) minv = green;
		delta = maxv - minv;

		// Blue wins a tie over green, and green over red.
		if (maxv == blue) begin
			sector = SECT_BLUE;
			pos    = red;
			neg    = green;
		end else if (maxv == green) begin
			sector = SECT_GREEN;
			pos    = blue;
			neg    = red;
		end else begin
			sector = SECT_RED;
			pos    = green;
			neg    = blue;
		end

		// pos - neg + delta lies in 0..2*delta, so the hue numerator is
		// 60 * that, and the quotient stays in 0..120.
		span     = {2'b00, pos} + {2'b00, delta} - {2'b00, neg};
		span_ext = {{(DIV_N_W-CHAN_W-2){1'b0}}, span};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_s1.hue_num <= (span_ext << 6) - (span_ext << 2);
			front_s1.sat_num <= {delta, {(DIV_N_W-CHAN_W){1'b0}}};
			front_s1.delta   <= delta;
			front_s1.maxv    <= maxv;
			front_s1.sector  <= sector;
			front_s1.grey    <= (delta == '0);
			front_s1.black   <= (maxv == '0);
		end
	end

	assign front = front_s1;
endmodule

>>> hdl/rgbhsv_div.sv
module rgbhsv_div (
	input  logic                                 clk,
	input  logic [rgbhsv_pkg::DIV_STAGES-1:0]    adv,
	input  logic [rgbhsv_pkg::DIV_N_W-1:0]       dividend,
	input  logic [rgbhsv_pkg::CHAN_W-1:0]        divisor,
	output logic [rgbhsv_pkg::DIV_Q_W-1:0]       quotient
);
	import rgbhsv_pkg::*;

	localparam int HI_W = DIV_N_W - DIV_Q_W;

	div_step_t                 step_a;
	div_step_t                 step_b;
	div_step_t                 step_c;

	logic [CHAN_W-1:0]         rem_s2;
	logic [CHAN_W-1:0]         dvs_s2;
	logic [2*DIV_STEP-1:0]     low_s2;
	logic [DIV_STEP-1:0]       quo_s2;

	logic [CHAN_W-1:0]         rem_s3;
	logic [CHAN_W-1:0]         dvs_s3;
	logic [DIV_STEP-1:0]       low_s3;
	logic [2*DIV_STEP-1:0]     quo_s3;

	logic [DIV_Q_W-1:0]        quo_s4;

	// The quotient fits DIV_Q_W bits, so the upper dividend bits start as the
	// partial remainder and are already below the divisor.
	assign step_a = div_step({{(CHAN_W-HI_W){1'b0}}, dividend[DIV_N_W-1:DIV_Q_W]},
		dividend[DIV_Q_W-1:DIV_Q_W-DIV_STEP], divisor);
	assign step_b = div_step(rem_s2, low_s2[2*DIV_STEP-1:DIV_STEP], dvs_s2);
	assign step_c = div_step(rem_s3, low_s3, dvs_s3);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s2 <= step_a.rem;
			quo_s2 <= step_a.quo;
			dvs_s2 <= divisor;
			low_s2 <= dividend[2*DIV_STEP-1:0];
		end
		if (adv[1]) begin
			rem_s3 <= step_b.rem;
			quo_s3 <= {quo_s2, step_b.quo};
			dvs_s3 <= dvs_s2;
			low_s3 <= low_s2[DIV_STEP-1:0];
		end
		if (adv[2]) begin
			quo_s4 <= {quo_s3, step_c.quo};
		end
	end

	assign quotient = quo_s4;
endmodule

>>> hdl/rgb_to_hsv_pixel_unit.sv
// RGB to HSV pixel converter.
// Pixels enter on the rgb channel (red, green, blue bytes) and leave on the
// hsv channel as hue in whole degrees (0..359, 0 for grey), saturation as a
// Q1.8 fraction (256 means one, 0 for black) and brightness, the largest byte.
// Both channels use a valid/ready handshake; an item moves on a clock edge at
// which both are high.
// The pipeline has five register stages: channel compare and numerator setup,
// three stages of shift-and-subtract division (three quotient bits each, hue
// and saturation dividers side by side), and the output register. An item
// accepted on rgb passes through these stages in order before it leaves on
// hsv, and the unit takes one item every cycle while hsv.ready is high.
// When the receiver stalls, each stage holds its item and empty stages behind
// it keep filling, so up to five items are held before rgb.ready drops.
// Asynchronous reset clears all valid bits; the pipeline starts out empty.
module rgb_to_hsv_pixel_unit (
	input  logic         clk,
	input  logic         arst_n,
	rgbhsv_rgb_if.sink   rgb,
	rgbhsv_hsv_if.source hsv
);
	import rgbhsv_pkg::*;

	localparam int NSTG = DIV_STAGES + 2;

	logic [NSTG-1:0]    vld_q;
	logic [NSTG-1:0]    en;
	front_t             front;
	logic [DIV_Q_W-1:0] hue_quo;
	logic [DIV_Q_W-1:0] sat_quo;
	side_t              side_s2;
	side_t              side_s3;
	side_t              side_s4;
	logic [HUE_W-1:0]   hue_sum;
	logic [HUE_W-1:0]   hue_next;
	logic [HUE_W-1:0]   hue_s5;
	logic [SAT_W-1:0]   sat_s5;
	logic [CHAN_W-1:0]  bri_s5;

	// A stage takes a new item when it is empty or its item moves on.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || hsv.ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= rgb.valid;
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign rgb.ready = en[0];

	rgbhsv_front u_front (
		.clk   (clk),
		.load  (en[0]),
		.red   (rgb.red),
		.green (rgb.green),
		.blue  (rgb.blue),
		.front (front)
	);

	rgbhsv_div u_hue_div (
		.clk      (clk),
		.adv      (en[DIV_STAGES:1]),
		.dividend (front.hue_num),
		.divisor  (front.delta),
		.quotient (hue_quo)
	);

	rgbhsv_div u_sat_div (
		.clk      (clk),
		.adv      (en[DIV_STAGES:1]),
		.dividend (front.sat_num),
		.divisor  (front.maxv),
		.quotient (sat_quo)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= '{sector: front.sector, grey: front.grey, black: front.black,
				maxv: front.maxv};
		end
		if (en[2]) side_s3 <= side_s2;
		if (en[3]) side_s4 <= side_s3;
	end

	always_comb begin
		case (side_s4.sector)
			SECT_BLUE:  hue_sum = HUE_OFS_BLUE + hue_quo;
			SECT_GREEN: hue_sum = HUE_OFS_GREEN + hue_quo;
			SECT_RED:   hue_sum = HUE_OFS_RED + hue_quo;
			default:    hue_sum = '0;
		endcase
		// Only the red sector can pass 360 and wraps back into range.
		if (hue_sum >= HUE_FULL) begin
			hue_next = hue_sum - HUE_FULL;
		end else begin
			hue_next = hue_sum;
		end
		if (side_s4.grey) hue_next = '0;
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			hue_s5 <= hue_next;
			sat_s5 <= side_s4.black ? '0 : sat_quo;
			bri_s5 <= side_s4.maxv;
		end
	end

	assign hsv.valid      = vld_q[NSTG-1];
	assign hsv.hue        = hue_s5;
	assign hsv.saturation = sat_s5;
	assign hsv.brightness = bri_s5;
endmodule

>>> tb/rgb_to_hsv_pixel_unit_test.sv
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_unit_test;
	import rgbhsv_pkg::*;

	localparam int PIXEL_COUNT     = 1830;
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 12;
	localparam int REPORT_LIMIT    = 10;

	// Grey, black, white, pure and mixed primaries, ties and the hue wrap near 360.
	localparam logic [23:0] OPENING_PIXELS [24] = '{
		24'h000000, 24'hffffff, 24'h010101, 24'h808080, 24'hff0000, 24'h00ff00,
		24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff0001, 24'hff0100,
		24'h010000, 24'h000100, 24'h000001, 24'hfffefe, 24'hfeffff, 24'hc86432,
		24'h3264c8, 24'h64c832, 24'h0a141e, 24'hff8000, 24'h0080ff, 24'h8000ff
	};

	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_pixel_t;

	class hsv_scoreboard;
		hsv_pixel_t  awaited[$];
		int unsigned failures;

		function hsv_pixel_t hsv_of_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
			logic [CHAN_W-1:0] b);
			hsv_pixel_t px;
			int rv, gv, bv, hi, lo, span, deg;
			rv = int'(r);
			gv = int'(g);
			bv = int'(b);
			hi = (rv > gv) ? rv : gv;
			hi = (bv > hi) ? bv : hi;
			lo = (rv < gv) ? rv : gv;
			lo = (bv < lo) ? bv : lo;
			span = hi - lo;
			// The sector offset is folded into the numerator so that the division
			// sees a non-negative value and truncation equals floor.
			if (span == 0)
				deg = 0;
			else if (bv == hi)
				deg = (60 * (rv - gv) + 240 * span) / span;
			else if (gv == hi)
				deg = (60 * (bv - rv) + 120 * span) / span;
			else
				deg = ((60 * (gv - bv) + 360 * span) / span) % 360;
			px.red = r;
			px.green = g;
			px.blue = b;
			px.hue = HUE_W'(deg);
			px.saturation = (hi == 0) ? '0 : SAT_W'((256 * span) / hi);
			px.brightness = CHAN_W'(hi);
			return px;
		endfunction

		function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
			logic [CHAN_W-1:0] b);
			awaited.push_back(hsv_of_pixel(r, g, b));
		endfunction

		function void check_result(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
			logic [CHAN_W-1:0] bright);
			hsv_pixel_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("result with no pixel pending: hue %0d sat %0d value %0d",
						hue, sat, bright);
				return;
			end
			want = awaited.pop_front();
			if (want.hue !== hue || want.saturation !== sat || want.brightness !== bright) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("pixel (%0d,%0d,%0d): expected %0d/%0d/%0d, got %0d/%0d/%0d",
						want.red, want.green, want.blue, want.hue, want.saturation,
						want.brightness, hue, sat, bright);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;
	int   hold_requests;
	hsv_scoreboard sb;

	rgbhsv_rgb_if rgb_ch ();
	rgbhsv_hsv_if hsv_ch ();

	rgb_to_hsv_pixel_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb_ch),
		.hsv    (hsv_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [CHAN_W-1:0] near(logic [CHAN_W-1:0] base);
		int v;
		v = int'(base) + int'($urandom_range(4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return CHAN_W'(v);
	endfunction

	task automatic pick_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
		output logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] corners [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
		logic [CHAN_W-1:0] top;
		int k;
		r = CHAN_W'($urandom_range(255));
		g = CHAN_W'($urandom_range(255));
		b = CHAN_W'($urandom_range(255));
		k = $urandom_range(2);
		case ($urandom_range(9))
			5: begin
				g = r;
				b = r;
			end
			6: begin
				// At least two channels share the maximum, so the tie rule picks the sector.
				top = CHAN_W'($urandom_range(255));
				r = top;
				g = top;
				b = top;
				if (k == 0)
					r = CHAN_W'($urandom_range(top));
				else if (k == 1)
					g = CHAN_W'($urandom_range(top));
				else
					b = CHAN_W'($urandom_range(top));
			end
			7: begin
				g = near(r);
				b = near(r);
			end
			8: begin
				r = corners[$urandom_range(3)];
				g = corners[$urandom_range(3)];
				b = corners[$urandom_range(3)];
			end
			9: begin
				top = $urandom_range(1) ? 8'd255 : 8'd0;
				if (k == 0)
					r = top;
				else if (k == 1)
					g = top;
				else
					b = top;
			end
			default: begin
			end
		endcase
	endtask

	task automatic offer(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b);
		rgb_ch.valid <= 1'b1;
		rgb_ch.red <= r;
		rgb_ch.green <= g;
		rgb_ch.blue <= b;
		do @(posedge clk); while (!rgb_ch.ready);
		sb.note_pixel(r, g, b);
		if (!steady && $urandom_range(99) < 8) begin
			rgb_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin
		logic [CHAN_W-1:0] r, g, b;
		sb = new;
		steady = 1'b0;
		hold_requests = 0;
		arst_n <= 1'b0;
		rgb_ch.valid <= 1'b0;
		rgb_ch.red <= '0;
		rgb_ch.green <= '0;
		rgb_ch.blue <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_PIXELS[i])
			offer(OPENING_PIXELS[i][23:16], OPENING_PIXELS[i][15:8], OPENING_PIXELS[i][7:0]);

		for (int n = 0; n < PIXEL_COUNT; n++) begin
			steady = (n >= 900 && n < 1150);
			if (n == 400 || n == 1400)
				hold_requests++;
			// Let the pipeline run dry before carrying on.
			if (n == 700 || n == 1600) begin
				rgb_ch.valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			pick_pixel(r, g, b);
			offer(r, g, b);
		end
		rgb_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("rgb_to_hsv_pixel_unit verification clean");
		else
			$display("rgb_to_hsv_pixel_unit verification failed");
		$finish;
	end

	// Result side: checks each item taken and decides ready for the next edge.
	initial begin
		int hold_left;
		int holds_taken;
		hold_left = 0;
		holds_taken = 0;
		hsv_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hsv_ch.valid && hsv_ch.ready)
				sb.check_result(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
			if (hold_left == 0 && holds_taken < hold_requests) begin
				holds_taken++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hsv_ch.ready <= 1'b0;
			end else begin
				hsv_ch.ready <= steady || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((rgb_ch.valid && rgb_ch.ready) || (hsv_ch.valid && hsv_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("rgb_to_hsv_pixel_unit verification failed");
				$finish;
			end
		end
	end

endmodule
